// ===== src/ttdh_pkg.sv =====
package ttdh_pkg;

  localparam int unsigned TrigWidth  = 32;
  localparam int unsigned TimeWidth  = 64;
  localparam int unsigned IdxWidth   = 14;
  localparam int unsigned OutCntWidth = 32;

  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_LOOKUP,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic evaluate;
    logic lookup;
    logic commit;
    logic clear_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/trigger_time_difference_histogram_core.sv =====
// Time-interval histogram of trigger events. Each item is either a timed
// event or a request to read one bin; every item gives exactly one result.
// After reset the block sweeps the bin memory to zero, one bin per cycle,
// so it holds off input until every bin has been cleared. It then handles
// one item at a time, in the steps capture, difference and range check,
// memory read, and counter update and result register, in that order; the
// read-modify-write of the bin counter must finish before the next item is
// taken. The result is registered in the last of these steps. A new item is
// taken while a result still waits in the output register, but its own
// result is held back until that register has been emptied.
module trigger_time_difference_histogram_core import ttdh_pkg::*; #(
  parameter int unsigned NUM_BINS   = 16384,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic signed [TrigWidth-1:0] trigger_number_i,
  input  logic [TimeWidth-1:0]        timestamp_ns_i,
  input  logic [IdxWidth-1:0]         bin_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic                        binned_o,
  output logic [TimeWidth-1:0]        time_diff_o,
  output logic [OutCntWidth-1:0]      bin_count_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ttdh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttdh_datapath #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .func_i           (func_i),
    .trigger_number_i (trigger_number_i),
    .timestamp_ns_i   (timestamp_ns_i),
    .bin_index_i      (bin_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .binned_o         (binned_o),
    .time_diff_o      (time_diff_o),
    .bin_count_o      (bin_count_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Input transfer was not followed by back-pressure.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && binned_o) |-> accepted_o)
    else $error("Binned result without an accepted event.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (time_diff_o == '0))
    else $error("Time difference reported for an event that was not accepted.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (bin_count_o == '0))
    else $error("Bin count reported for an event result.");

endmodule

// ===== src/ttdh_ram.sv =====
module ttdh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ttdh_ctrl.sv =====
module ttdh_ctrl import ttdh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.evaluate = 1'b1;
        state_d        = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/ttdh_datapath.sv =====
module ttdh_datapath import ttdh_pkg::*; #(
  parameter int unsigned NUM_BINS   = 16384,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             status_o,
  input  logic                   func_i,
  input  logic signed [TrigWidth-1:0] trigger_number_i,
  input  logic [TimeWidth-1:0]   timestamp_ns_i,
  input  logic [IdxWidth-1:0]    bin_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   accepted_o,
  output logic                   binned_o,
  output logic [TimeWidth-1:0]   time_diff_o,
  output logic [OutCntWidth-1:0] bin_count_o
);

  localparam int unsigned AddrWidth = $clog2(NUM_BINS);
  localparam logic [AddrWidth-1:0] LastBin = AddrWidth'(NUM_BINS - 1);

  logic                        func_q;
  logic signed [TrigWidth-1:0] trig_q;
  logic [TimeWidth-1:0]        ts_q;
  logic [IdxWidth-1:0]         idx_q;

  logic                 started_q;
  logic [TrigWidth-1:0] ref_trig_q;
  logic [TimeWidth-1:0] ref_time_q;

  logic                 is_read_q;
  logic                 take_q;
  logic                 in_range_q;
  logic                 idx_ok_q;
  logic [TimeWidth-1:0] dt_q;

  logic                 out_valid_q;
  logic                 accepted_q;
  logic                 binned_q;
  logic [TimeWidth-1:0] time_diff_q;
  logic [OutCntWidth-1:0] bin_count_q;

  logic [AddrWidth-1:0] clr_cnt_q;

  logic [TimeWidth-1:0] dt_d;
  logic                 is_read_d;
  logic                 start_d;
  logic                 take_d;
  logic [31:0]          idx_ext;

  logic                  ram_we;
  logic [AddrWidth-1:0]  ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AddrWidth-1:0]  ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [63:0]           cnt_ext;

  assign dt_d      = ts_q - ref_time_q;
  assign is_read_d = (func_q == FUNC_READ);
  assign start_d   = !is_read_d && !started_q && (trig_q == 32'sd1);
  assign take_d    = !is_read_d && started_q && (trig_q > 32'sd0) &&
                     (TrigWidth'(trig_q) != ref_trig_q);
  assign idx_ext   = 32'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      trig_q <= trigger_number_i;
      ts_q   <= timestamp_ns_i;
      idx_q  <= bin_index_i;
    end
    if (cmd_i.evaluate) begin
      is_read_q  <= is_read_d;
      take_q     <= take_d;
      dt_q       <= dt_d;
      in_range_q <= (dt_d < 64'(NUM_BINS));
      idx_ok_q   <= (idx_ext < 32'(NUM_BINS));
    end
    if (cmd_i.commit) begin
      accepted_q  <= take_q;
      binned_q    <= take_q && in_range_q;
      time_diff_q <= take_q ? dt_q : '0;
      bin_count_q <= (is_read_q && idx_ok_q) ? cnt_ext[OutCntWidth-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      ref_trig_q  <= '0;
      ref_time_q  <= '0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (cmd_i.evaluate && (start_d || take_d)) begin
        started_q  <= 1'b1;
        ref_trig_q <= TrigWidth'(trig_q);
        ref_time_q <= ts_q;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear_wr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // A full counter keeps its value.
  assign cnt_inc = (ram_rdata == {COUNT_BITS{1'b1}}) ? ram_rdata : ram_rdata + 1'b1;
  assign cnt_ext = 64'(ram_rdata);

  assign ram_we    = cmd_i.clear_wr || (cmd_i.commit && take_q && in_range_q);
  assign ram_waddr = cmd_i.clear_wr ? clr_cnt_q : dt_q[AddrWidth-1:0];
  assign ram_wdata = cmd_i.clear_wr ? '0 : cnt_inc;
  assign ram_raddr = is_read_q ? idx_ext[AddrWidth-1:0] : dt_q[AddrWidth-1:0];

  ttdh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.lookup),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.clear_last = (clr_cnt_q == LastBin);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;
  assign binned_o    = binned_q;
  assign time_diff_o = time_diff_q;
  assign bin_count_o = bin_count_q;

endmodule
